[sv/yta_pkg.sv]
// yta_pkg: shared types and constants for the yuyv to argb converter
// no dependencies; used by every module of the block

package yta_pkg;

    localparam int TERM_W = 27;

    // q16 color coefficients, rounded to nearest
    localparam logic signed [TERM_W-1:0] COEF_RED_CR   = 27'sd92242;
    localparam logic signed [TERM_W-1:0] COEF_GREEN_CB = 27'sd22643;
    localparam logic signed [TERM_W-1:0] COEF_GREEN_CR = 27'sd46983;
    localparam logic signed [TERM_W-1:0] COEF_BLUE_CB  = 27'sd116589;

    localparam int         FRAC_BITS   = 16;
    localparam logic [7:0] CHANNEL_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       frame_end;
    } t_yuyv_in;

    typedef struct packed {
        logic [23:0] pixel_first;
        logic [23:0] pixel_second;
        logic        frame_end_out;
    } t_argb_out;

    typedef struct packed {
        logic signed [TERM_W-1:0] red;
        logic signed [TERM_W-1:0] green;
        logic signed [TERM_W-1:0] blue;
    } t_chroma_terms;

endpackage

[sv/yta_chroma.sv]
// yta_chroma: q16 chroma contributions shared by both pixels of a pair
// depends on yta_pkg

module yta_chroma (
    input  logic [7:0]             i_chroma_blue,
    input  logic [7:0]             i_chroma_red,
    output yta_pkg::t_chroma_terms o_terms
);

    logic signed [7:0]                  cb_off;
    logic signed [7:0]                  cr_off;
    logic signed [yta_pkg::TERM_W-1:0]  cb_ext;
    logic signed [yta_pkg::TERM_W-1:0]  cr_ext;

    // offset from 128 is the byte with its top bit flipped
    assign cb_off = signed'({~i_chroma_blue[7], i_chroma_blue[6:0]});
    assign cr_off = signed'({~i_chroma_red[7], i_chroma_red[6:0]});

    assign cb_ext = signed'({{(yta_pkg::TERM_W-8){cb_off[7]}}, cb_off});
    assign cr_ext = signed'({{(yta_pkg::TERM_W-8){cr_off[7]}}, cr_off});

    assign o_terms.red   = yta_pkg::COEF_RED_CR * cr_ext;
    assign o_terms.green = -(yta_pkg::COEF_GREEN_CB * cb_ext)
                           - (yta_pkg::COEF_GREEN_CR * cr_ext);
    assign o_terms.blue  = yta_pkg::COEF_BLUE_CB * cb_ext;

endmodule

[sv/yta_pixel.sv]
// yta_pixel: adds luma to the chroma terms, truncates and clamps one pixel
// depends on yta_pkg

module yta_pixel (
    input  logic [7:0]             i_luma,
    input  yta_pkg::t_chroma_terms i_terms,
    output logic [23:0]            o_pixel
);

    logic signed [yta_pkg::TERM_W-1:0] base;
    logic signed [yta_pkg::TERM_W-1:0] sum_r;
    logic signed [yta_pkg::TERM_W-1:0] sum_g;
    logic signed [yta_pkg::TERM_W-1:0] sum_b;

    function automatic logic [7:0] clamp_q16(input logic signed [yta_pkg::TERM_W-1:0] sum);
        logic [yta_pkg::TERM_W-yta_pkg::FRAC_BITS-2:0] whole;
        whole = sum[yta_pkg::TERM_W-2:yta_pkg::FRAC_BITS];
        if (sum[yta_pkg::TERM_W-1]) begin
            clamp_q16 = 8'd0;
        end else if (whole > {2'b00, yta_pkg::CHANNEL_MAX}) begin
            clamp_q16 = yta_pkg::CHANNEL_MAX;
        end else begin
            clamp_q16 = whole[7:0];
        end
    endfunction

    assign base  = signed'({3'b000, i_luma, 16'h0000});
    assign sum_r = base + i_terms.red;
    assign sum_g = base + i_terms.green;
    assign sum_b = base + i_terms.blue;

    assign o_pixel = {clamp_q16(sum_r), clamp_q16(sum_g), clamp_q16(sum_b)};

endmodule

[sv/yuyv_to_argb_converter.sv]
// yuyv_to_argb_converter: top level, input register, color math, result register
// depends on yta_pkg, yta_chroma, yta_pixel

// Converts one YUYV 4:2:2 pair into two 24-bit RGB pixels per transaction.
// A transaction is taken whenever start is high; busy is never raised, so one
// pair can enter every clock. The result appears on o_result with o_done high
// for one cycle, once the transaction has passed the input register and then
// the multipliers and clamps into the result register. The receiver cannot
// stall the block and must take every result.

module yuyv_to_argb_converter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  yta_pkg::t_yuyv_in   i_item,
    output logic                busy,
    output logic                o_done,
    output yta_pkg::t_argb_out  o_result
);

    logic                   r_in_valid;
    yta_pkg::t_yuyv_in      r_in;
    logic                   r_done;
    yta_pkg::t_argb_out     r_out;
    yta_pkg::t_argb_out     n_out;
    yta_pkg::t_chroma_terms terms;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
            r_done     <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    yta_chroma u_chroma (
        .i_chroma_blue (r_in.chroma_blue),
        .i_chroma_red  (r_in.chroma_red),
        .o_terms       (terms)
    );

    yta_pixel u_pixel_first (
        .i_luma  (r_in.luma_first),
        .i_terms (terms),
        .o_pixel (n_out.pixel_first)
    );

    yta_pixel u_pixel_second (
        .i_luma  (r_in.luma_second),
        .i_terms (terms),
        .o_pixel (n_out.pixel_second)
    );

    assign n_out.frame_end_out = r_in.frame_end;

    assign o_done   = r_done;
    assign o_result = r_out;

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("transaction taken without a result two cycles later");

    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 2))
        else $error("result without a transaction two cycles earlier");

    a_frame_end_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.frame_end_out == $past(i_item.frame_end, 2)))
        else $error("frame end marker not carried through");

endmodule
